FILE: sv/atgr_pkg.sv
// Shared types and constants for the animated text glyph renderer.
// No dependencies; imported by the renderer core.
`default_nettype none

package atgr_pkg;

    localparam int FONT_BYTES   = 2048;
    localparam int FONT_AW      = $clog2(FONT_BYTES);
    localparam int ADDRESS_BITS = 20;

    typedef enum logic [1:0] {
        OP_LOAD_GLYPH = 2'd0,
        OP_START      = 2'd1,
        OP_CHAR       = 2'd2,
        OP_END        = 2'd3
    } op_t;

    // configuration register indexes
    localparam logic [1:0] CFG_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;
    localparam logic [1:0] CFG_STRIDE  = 2'd2;

    typedef struct packed {
        op_t         operation;
        logic [7:0]  char_code;
        logic [10:0] font_index;
        logic [7:0]  font_bits;
        logic [7:0]  start_col;
        logic [7:0]  start_row;
        logic [15:0] frame_budget;
    } in_word_t;

    typedef struct packed {
        logic                    pixel_valid;
        logic [ADDRESS_BITS-1:0] pixel_address;
        logic [15:0]             pixel_color;
        logic                    last;
        logic                    string_done;
        logic                    string_ok;
    } out_word_t;

endpackage

`default_nettype wire

FILE: sv/atgr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the glyph store.
`default_nettype none

module atgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/animated_text_glyph_renderer_core.sv
// Animated 8x8 text renderer core; uses atgr_pkg and one atgr_ram glyph store.
// Load, start and character words that draw nothing are taken in the idle state; an end
// string word moves to the end state, and its result word is registered once the output
// register is free. A drawn character passes the accepting cycle, the bit-serial row*stride
// multiply and a state that primes the glyph read, then gives 64 pixel words at one per cycle
// while the output is not stalled; each output stall holds the pixel words back.
// Synchronous active-low reset clears control state; the glyph store is not cleared.
`default_nettype none

module animated_text_glyph_renderer_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // input words
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire atgr_pkg::in_word_t  s_data,
    // result words
    output logic                     m_valid,
    input  wire logic                m_ready,
    output atgr_pkg::out_word_t      m_data,
    // configuration writes
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [12:0]         cfg_data
);

    import atgr_pkg::*;

    localparam int AB = ADDRESS_BITS;

    // fade palette, picked by min(frames left, 3) - 1
    localparam logic [15:0] FADE_PALETTE [3] = '{16'd65535, 16'd40314, 16'd17141};

    localparam logic [7:0] CODE_NEWLINE = 8'd10;
    localparam logic [7:0] CODE_SPACE   = 8'd32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PRIME,
        ST_EMIT,
        ST_END
    } state_t;

    state_t      state_reg;

    // configuration
    logic [8:0]  columns_reg;
    logic [8:0]  rows_reg;
    logic [12:0] stride_reg;

    // string state
    logic [7:0]  cursor_col_reg;
    logic [7:0]  cursor_row_reg;
    logic [7:0]  line_start_reg;
    logic [17:0] frames_reg;          // two's complement
    logic        prev_space_reg;
    logic        drop_reg;

    // character in flight
    logic [7:0]    code_reg;
    logic [15:0]   color_reg;
    logic [7:0]    row_sr_reg;        // multiplier bits, LSB first
    logic [AB-1:0] mcand_reg;         // stride*8, shifted left each step
    logic [AB-1:0] base_reg;          // product accumulator, then line base
    logic [2:0]    mul_cnt_reg;
    logic [2:0]    rd_line_reg;
    logic          rd_ok_reg;
    logic [7:0]    bits_sr_reg;       // glyph row, leftmost pixel at bit 7
    logic [5:0]    pix_cnt_reg;

    logic          m_valid_reg;
    out_word_t     m_data_reg;

    logic          in_take;
    logic          out_free;
    logic          out_load;
    logic          rd_en;
    logic [10:0]   rd_glyph_addr;
    logic          rd_in_range;
    logic [7:0]    ram_q;
    logic [7:0]    glyph_q;
    logic          glyph_we;
    logic          is_newline;
    logic          is_space;
    logic          frames_pos;
    logic          visible;
    logic [1:0]    pick;
    logic [7:0]    col_inc;
    logic [7:0]    row_inc;
    logic [17:0]   frames_next;
    out_word_t     pixel_word;
    out_word_t     end_word;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign in_take  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    // a new result word enters the output register
    assign out_load = out_free && ((state_reg == ST_EMIT) || (state_reg == ST_END));

    // glyph store
    assign glyph_we = in_take && (s_data.operation == OP_LOAD_GLYPH)
                      && (32'(s_data.font_index) < FONT_BYTES);

    assign rd_glyph_addr = {code_reg, rd_line_reg};
    assign rd_in_range   = 32'(rd_glyph_addr) < FONT_BYTES;
    // next line fetched at end of multiply, while priming, and on each line's last pixel
    assign rd_en = ((state_reg == ST_MUL) && (mul_cnt_reg == 3'd7))
                   || (state_reg == ST_PRIME)
                   || ((state_reg == ST_EMIT) && out_free && (pix_cnt_reg[2:0] == 3'd7));

    atgr_ram #(
        .WIDTH (8),
        .DEPTH (FONT_BYTES)
    ) u_glyph_ram (
        .aclk    (aclk),
        .wr_en   (glyph_we),
        .wr_addr (s_data.font_index[FONT_AW-1:0]),
        .wr_data (s_data.font_bits),
        .rd_en   (rd_en),
        .rd_addr (rd_glyph_addr[FONT_AW-1:0]),
        .rd_data (ram_q)
    );

    // bytes outside the store read as blank
    assign glyph_q = rd_ok_reg ? ram_q : 8'd0;

    // character decode
    assign is_newline = (s_data.char_code == CODE_NEWLINE);
    assign is_space   = is_newline || (s_data.char_code == CODE_SPACE);
    assign frames_pos = !frames_reg[17] && (frames_reg != 18'd0);
    assign visible    = ({1'b0, cursor_col_reg} < columns_reg)
                        && ({1'b0, cursor_row_reg} < rows_reg);
    assign pick       = (frames_reg < 18'd3) ? (frames_reg[1:0] - 2'd1) : 2'd2;
    assign col_inc    = (cursor_col_reg == 8'hFF) ? cursor_col_reg : cursor_col_reg + 8'd1;
    assign row_inc    = (cursor_row_reg == 8'hFF) ? cursor_row_reg : cursor_row_reg + 8'd1;
    // a run of spaces and newlines is charged once
    assign frames_next = (prev_space_reg && is_space) ? frames_reg : frames_reg - 18'd3;

    always_comb begin
        pixel_word               = '0;
        pixel_word.pixel_valid   = 1'b1;
        pixel_word.pixel_address = base_reg + AB'(pix_cnt_reg[2:0]);
        pixel_word.pixel_color   = bits_sr_reg[7] ? color_reg : 16'd0;
        pixel_word.last          = (pix_cnt_reg == 6'd63);

        end_word             = '0;
        end_word.last        = 1'b1;
        end_word.string_done = 1'b1;
        end_word.string_ok   = !drop_reg && !frames_reg[17];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            columns_reg    <= 9'd40;
            rows_reg       <= 9'd30;
            stride_reg     <= 13'd320;
            cursor_col_reg <= 8'd0;
            cursor_row_reg <= 8'd0;
            line_start_reg <= 8'd0;
            frames_reg     <= 18'd0;
            prev_space_reg <= 1'b0;
            drop_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
            mul_cnt_reg    <= 3'd0;
            rd_line_reg    <= 3'd0;
            pix_cnt_reg    <= 6'd0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_COLUMNS: columns_reg <= cfg_data[8:0];
                    CFG_ROWS:    rows_reg    <= cfg_data[8:0];
                    CFG_STRIDE:  stride_reg  <= cfg_data;
                    default: ;
                endcase
            end

            // output register: load a new word, else empty it once taken
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (rd_en) begin
                rd_ok_reg   <= rd_in_range;
                rd_line_reg <= rd_line_reg + 3'd1;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_take) begin
                        unique case (s_data.operation)
                            OP_LOAD_GLYPH: ;
                            OP_START: begin
                                cursor_col_reg <= s_data.start_col;
                                line_start_reg <= s_data.start_col;
                                cursor_row_reg <= s_data.start_row;
                                frames_reg     <= {2'b00, s_data.frame_budget};
                                prev_space_reg <= 1'b0;
                                drop_reg       <= 1'b0;
                            end
                            OP_END: begin
                                state_reg <= ST_END;
                            end
                            OP_CHAR: begin
                                if (!frames_pos) begin
                                    drop_reg <= 1'b1;
                                end else begin
                                    frames_reg     <= frames_next;
                                    prev_space_reg <= is_space;
                                    if (is_newline) begin
                                        cursor_col_reg <= line_start_reg;
                                        cursor_row_reg <= row_inc;
                                    end else begin
                                        cursor_col_reg <= col_inc;
                                    end
                                    if (!is_space && visible) begin
                                        state_reg   <= ST_MUL;
                                        code_reg    <= s_data.char_code;
                                        color_reg   <= FADE_PALETTE[pick];
                                        row_sr_reg  <= cursor_row_reg;
                                        mcand_reg   <= AB'({stride_reg, 3'b000});
                                        base_reg    <= AB'({cursor_col_reg, 3'b000});
                                        mul_cnt_reg <= 3'd0;
                                        rd_line_reg <= 3'd0;
                                        pix_cnt_reg <= 6'd0;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                // base = col*8 + row*8*stride, one multiplier bit a cycle
                ST_MUL: begin
                    if (row_sr_reg[0]) begin
                        base_reg <= base_reg + mcand_reg;
                    end
                    mcand_reg   <= {mcand_reg[AB-2:0], 1'b0};
                    row_sr_reg  <= {1'b0, row_sr_reg[7:1]};
                    mul_cnt_reg <= mul_cnt_reg + 3'd1;
                    if (mul_cnt_reg == 3'd7) begin
                        state_reg <= ST_PRIME;
                    end
                end

                ST_PRIME: begin
                    bits_sr_reg <= glyph_q;
                    state_reg   <= ST_EMIT;
                end

                ST_EMIT: begin
                    if (out_free) begin
                        m_data_reg  <= pixel_word;
                        pix_cnt_reg <= pix_cnt_reg + 6'd1;
                        if (pix_cnt_reg[2:0] == 3'd7) begin
                            bits_sr_reg <= glyph_q;
                            base_reg    <= base_reg + AB'(stride_reg);
                        end else begin
                            bits_sr_reg <= {bits_sr_reg[6:0], 1'b0};
                        end
                        if (pix_cnt_reg == 6'd63) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end

                ST_END: begin
                    if (out_free) begin
                        m_data_reg <= end_word;
                        state_reg  <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
